// File: src/led_grid_test_pattern_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// LED grid test pattern generator - assertion macros
// Shared concurrent assertion wrappers; they compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LED_GRID_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define LED_GRID_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, suspended while reset is high.
`define LGTPG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define LGTPG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LGTPG_ASSERT(label, clk, rst, prop, msg)
`define LGTPG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/lgtpg_pkg.sv
// ----------------------------------------------------------------------------
// LED grid test pattern generator - package
// Field widths, default parameters, pattern codes and shared control types.
// ----------------------------------------------------------------------------
package lgtpg_pkg;

   localparam int unsigned COL_W   = 3;
   localparam int unsigned ROW_W   = 3;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PAT_W   = 3;

   localparam int unsigned GRID_SIDE_DEFAULT        = 8;
   localparam int unsigned SINE_TABLE_DEPTH_DEFAULT = 1024;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_OFF  = 8'd0;

   typedef enum logic [PAT_W-1:0] {
      PAT_RED_DOT    = 3'd0,
      PAT_GREEN_DOT  = 3'd1,
      PAT_BLUE_BAND  = 3'd2,
      PAT_HUE_WHEEL  = 3'd3,
      PAT_CHECKER    = 3'd4,
      PAT_SINE_WHITE = 3'd5
   } pattern_type;

   // Per-frame control decoded from the frame number.
   typedef struct packed {
      pattern_type pattern;
      logic        checker_odd;
   } frame_ctl_type;

endpackage

// File: src/lgtpg_frame_decode.sv
// ----------------------------------------------------------------------------
// LED grid test pattern generator - frame decode
// Two-stage pipeline turning a frame number into pattern, sweep and sine index.
// ----------------------------------------------------------------------------
module lgtpg_frame_decode #(
   parameter int unsigned GRID_SIDE        = lgtpg_pkg::GRID_SIDE_DEFAULT,
   parameter int unsigned SINE_TABLE_DEPTH = lgtpg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [lgtpg_pkg::FRAME_W-1:0]         frame,
   output lgtpg_pkg::frame_ctl_type              ctl,
   output logic [$clog2(GRID_SIDE)-1:0]          sweep,
   output logic [$clog2(SINE_TABLE_DEPTH)-1:0]   sine_idx
);

   localparam int unsigned SWEEP_W     = $clog2(GRID_SIDE);
   localparam int unsigned IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned SWEEP_SHIFT = 29 + SWEEP_W;
   localparam longint unsigned SWEEP_MUL_FULL =
      ((64'd1 << SWEEP_SHIFT) + 64'(GRID_SIDE) - 64'd1) / 64'(GRID_SIDE);
   localparam logic [30:0]        SWEEP_MUL = 31'(SWEEP_MUL_FULL);
   localparam logic [SWEEP_W-1:0] GRID_LO   = SWEEP_W'(GRID_SIDE);

   // phase step = round(2^32 * 0.1 / (2*pi))
   localparam logic [31:0] PHASE_STEP   = 32'd68356528;
   // frame/300 = (frame>>2)/75, reciprocal with shift 37
   localparam logic [30:0] DIV300_MUL   = 31'd1832519380;
   // frame/30 = (frame>>1)/15, reciprocal with shift 35
   localparam logic [31:0] DIV30_MUL    = 32'd2290649225;

   // first stage products
   logic [31:0]        phase_in, phase_ff;
   logic [60:0]        q300_prod;
   logic [62:0]        q30_prod;
   logic [59:0]        sweep_prod;
   logic [23:0]        q300_in, q300_ff;
   logic               odd_in, odd_ff;
   logic [SWEEP_W-1:0] sweep_q_in, sweep_q_ff;
   logic [SWEEP_W-1:0] x3_lo_in, x3_lo_ff;

   // second stage
   logic [1:0]                 r3;
   logic [2:0]                 r6;
   lgtpg_pkg::frame_ctl_type   ctl_in, ctl_ff;
   logic [SWEEP_W-1:0]         sweep_in, sweep_ff;
   logic [44:0]                idx_prod;
   logic [IDX_W-1:0]           idx_in, idx_ff;

   // Residue mod 3 of a 24-bit value: 16 and 4 are both 1 mod 3.
   function automatic logic [1:0] mod3_24(input logic [23:0] v);
      logic [6:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8])
         + 7'(v[15:12]) + 7'(v[19:16]) + 7'(v[23:20]);
      s2 = 4'(s1[6]) + 4'(s1[5:4]) + 4'(s1[3:2]) + 4'(s1[1:0]);
      s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
      return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
   endfunction

   assign phase_in   = frame * PHASE_STEP;
   assign q300_prod  = 61'(frame[31:2]) * 61'(DIV300_MUL);
   assign q30_prod   = 63'(frame[31:1]) * 63'(DIV30_MUL);
   assign sweep_prod = 60'(frame[31:3]) * 60'(SWEEP_MUL);
   assign q300_in    = q300_prod[60:37];
   assign odd_in     = q30_prod[35];
   assign sweep_q_in = sweep_prod[SWEEP_SHIFT +: SWEEP_W];
   assign x3_lo_in   = frame[3 +: SWEEP_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         phase_ff   <= phase_in;
         q300_ff    <= q300_in;
         odd_ff     <= odd_in;
         sweep_q_ff <= sweep_q_in;
         x3_lo_ff   <= x3_lo_in;
      end
   end

   // q mod 6 from its parity and its residue mod 3
   assign r3 = mod3_24(q300_ff);
   assign r6 = (r3[0] == q300_ff[0]) ? {1'b0, r3} : (3'(r3) + 3'd3);

   always_comb begin
      ctl_in.checker_odd = odd_ff;
      unique case (r6)
         3'd0:    ctl_in.pattern = lgtpg_pkg::PAT_GREEN_DOT;
         3'd1:    ctl_in.pattern = lgtpg_pkg::PAT_BLUE_BAND;
         3'd2:    ctl_in.pattern = lgtpg_pkg::PAT_HUE_WHEEL;
         3'd3:    ctl_in.pattern = lgtpg_pkg::PAT_CHECKER;
         3'd4:    ctl_in.pattern = lgtpg_pkg::PAT_SINE_WHITE;
         default: ctl_in.pattern = lgtpg_pkg::PAT_RED_DOT;
      endcase
   end

   // remainder stays below GRID_SIDE, so low bits suffice
   assign sweep_in = x3_lo_ff - (sweep_q_ff * GRID_LO);
   assign idx_prod = 45'(phase_ff) * 45'(SINE_TABLE_DEPTH);
   assign idx_in   = idx_prod[32 +: IDX_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff   <= ctl_in;
         sweep_ff <= sweep_in;
         idx_ff   <= idx_in;
      end
   end

   assign ctl      = ctl_ff;
   assign sweep    = sweep_ff;
   assign sine_idx = idx_ff;

endmodule

// File: src/lgtpg_sine_rom.sv
// ----------------------------------------------------------------------------
// LED grid test pattern generator - sine level ROM
// White level 128+127*sin per table index, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module lgtpg_sine_rom #(
   parameter int unsigned SINE_TABLE_DEPTH = lgtpg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]  addr,
   output logic [lgtpg_pkg::CHAN_W-1:0]         level
);

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [7:0]  TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                8'd110, 8'd156, 8'd210};

   typedef logic [lgtpg_pkg::CHAN_W-1:0] level_table_type [SINE_TABLE_DEPTH];

   // Taylor series to x^15, angle in Q2.30 on [0, pi/2], clamped to [0, 1]
   function automatic logic [63:0] sine_q30(input logic [63:0] ang);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] res;
      longint      sum;
      x2   = (ang * ang) >> 30;
      term = ang;
      sum  = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
         if ((k % 2) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      res = 64'(sum);
      if (ang == 64'd0)        res = 64'd0;
      if (ang >= HALF_PI_Q30)  res = Q30_ONE;
      return res;
   endfunction

   function automatic logic [lgtpg_pkg::CHAN_W-1:0] level_of(input int unsigned idx);
      logic [63:0] ang;
      logic [63:0] m;
      logic        neg;
      ang = (64'(idx) * TWO_PI_Q30) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (ang > PI_Q30) begin
         neg = 1'b1;
         ang = ang - PI_Q30;
      end
      if (ang > HALF_PI_Q30) ang = (ang <= PI_Q30) ? (PI_Q30 - ang) : 64'd0;
      m = 64'd127 * sine_q30(ang);
      if (neg) return 8'(64'd128 - ((m + Q30_ONE - 64'd1) >> 30));
      return 8'(64'd128 + (m >> 30));
   endfunction

   function automatic level_table_type build_table();
      level_table_type t;
      for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) t[i] = level_of(i);
      return t;
   endfunction

   localparam level_table_type LEVELS = build_table();

   logic [lgtpg_pkg::CHAN_W-1:0] level_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= LEVELS[addr];
      end
   end

   assign level = level_ff;

endmodule

// File: src/lgtpg_pixel_shade.sv
// ----------------------------------------------------------------------------
// LED grid test pattern generator - pixel shader
// Colors for the dot, band, hue wheel and checker patterns; flags sine pixels.
// ----------------------------------------------------------------------------
module lgtpg_pixel_shade #(
   parameter int unsigned GRID_SIDE = lgtpg_pkg::GRID_SIDE_DEFAULT
) (
   input  logic [lgtpg_pkg::COL_W-1:0]   col,
   input  logic [lgtpg_pkg::ROW_W-1:0]   row,
   input  logic [7:0]                    frame_lo,
   input  logic [$clog2(GRID_SIDE)-1:0]  sweep,
   input  lgtpg_pkg::frame_ctl_type      ctl,
   output logic [lgtpg_pkg::CHAN_W-1:0]  red,
   output logic [lgtpg_pkg::CHAN_W-1:0]  green,
   output logic [lgtpg_pkg::CHAN_W-1:0]  blue,
   output logic                          use_sine
);

   localparam int unsigned SWEEP_W = $clog2(GRID_SIDE);
   localparam int unsigned CMP_W   = (SWEEP_W > 3) ? (SWEEP_W + 1) : 4;
   localparam logic [6:0]       GRID_7 = 7'(GRID_SIDE);
   localparam logic [CMP_W-1:0] GRID_C = CMP_W'(GRID_SIDE);

   logic             in_grid;
   logic [CMP_W-1:0] col_c, row_c, sweep_c, diag_sum, diag_mod;
   logic             on_dot;
   logic [7:0]       hue;
   logic [6:0]       hue_d;
   logic [7:0]       ramp_up, ramp_dn;

   assign in_grid  = (7'(col) < GRID_7) && (7'(row) < GRID_7);
   assign col_c    = CMP_W'(col);
   assign row_c    = CMP_W'(row);
   assign sweep_c  = CMP_W'(sweep);
   assign diag_sum = col_c + row_c;
   // inside the grid the sum stays below twice the side
   assign diag_mod = (diag_sum >= GRID_C) ? (diag_sum - GRID_C) : diag_sum;
   assign on_dot   = (col_c == sweep_c) && (row_c == sweep_c);

   assign hue = frame_lo + {col, 5'b0} + {row, 5'b0};

   always_comb begin
      if (hue < 8'd85)       hue_d = hue[6:0];
      else if (hue < 8'd170) hue_d = 7'(hue - 8'd85);
      else                   hue_d = 7'(hue - 8'd170);
   end

   assign ramp_up = {hue_d, 1'b0} + {1'b0, hue_d};
   assign ramp_dn = lgtpg_pkg::CHAN_FULL - ramp_up;

   always_comb begin
      red   = lgtpg_pkg::CHAN_OFF;
      green = lgtpg_pkg::CHAN_OFF;
      blue  = lgtpg_pkg::CHAN_OFF;
      if (in_grid) begin
         unique case (ctl.pattern)
            lgtpg_pkg::PAT_RED_DOT: begin
               if (on_dot) red = lgtpg_pkg::CHAN_FULL;
            end
            lgtpg_pkg::PAT_GREEN_DOT: begin
               if (on_dot) green = lgtpg_pkg::CHAN_FULL;
            end
            lgtpg_pkg::PAT_BLUE_BAND: begin
               if (diag_mod == sweep_c) blue = lgtpg_pkg::CHAN_FULL;
            end
            lgtpg_pkg::PAT_HUE_WHEEL: begin
               if (hue < 8'd85) begin
                  red   = ramp_dn;
                  green = ramp_up;
               end else if (hue < 8'd170) begin
                  green = ramp_dn;
                  blue  = ramp_up;
               end else begin
                  red   = ramp_up;
                  blue  = ramp_dn;
               end
            end
            lgtpg_pkg::PAT_CHECKER: begin
               if ((col[0] ^ row[0] ^ ctl.checker_odd) == 1'b1) begin
                  red   = lgtpg_pkg::CHAN_FULL;
                  green = lgtpg_pkg::CHAN_FULL;
                  blue  = lgtpg_pkg::CHAN_FULL;
               end
            end
            default: begin
               // sine white level comes from the ROM
            end
         endcase
      end
   end

   assign use_sine = in_grid && (ctl.pattern == lgtpg_pkg::PAT_SINE_WHITE);

endmodule

// File: src/led_grid_test_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// LED grid test pattern generator - top level
// One pixel request in, one RGB pixel plus pattern number out, per clock while no result is held.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_col, req_row, req_frame
//   rsp       out        rsp_valid/rsp_stall  rsp_red, rsp_green, rsp_blue,
//                                             rsp_pattern_in_use
//
// Throughput is one request per clock while no result is held. The depth is
// set by the frame decode: the reciprocal and phase multipliers, then the
// sine index multiplier, then the ROM read.
// Reset is synchronous and clears only the stage valid bits; no clearing
// pass is needed since the ROM is constant.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// while a result is waiting; otherwise every cycle takes a new request.
//
`include "led_grid_test_pattern_generator_unit_defines.svh"

module led_grid_test_pattern_generator_unit #(
   parameter int unsigned GRID_SIDE        = lgtpg_pkg::GRID_SIDE_DEFAULT,
   parameter int unsigned SINE_TABLE_DEPTH = lgtpg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lgtpg_pkg::COL_W-1:0]   req_col,
   input  logic [lgtpg_pkg::ROW_W-1:0]   req_row,
   input  logic [lgtpg_pkg::FRAME_W-1:0] req_frame,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lgtpg_pkg::CHAN_W-1:0]  rsp_red,
   output logic [lgtpg_pkg::CHAN_W-1:0]  rsp_green,
   output logic [lgtpg_pkg::CHAN_W-1:0]  rsp_blue,
   output logic [lgtpg_pkg::PAT_W-1:0]   rsp_pattern_in_use
);

   localparam int unsigned STAGES  = 5;
   localparam int unsigned SWEEP_W = $clog2(GRID_SIDE);
   localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);

   logic              advance;
   logic [STAGES-1:0] stage_valid_in, stage_valid_ff;

   // stage 0: input register
   logic [lgtpg_pkg::COL_W-1:0]   col0_ff;
   logic [lgtpg_pkg::ROW_W-1:0]   row0_ff;
   logic [lgtpg_pkg::FRAME_W-1:0] frame0_ff;

   // stages 1 and 2: pixel coordinates ride along with the frame decode
   logic [lgtpg_pkg::COL_W-1:0] col1_ff, col2_ff;
   logic [lgtpg_pkg::ROW_W-1:0] row1_ff, row2_ff;
   logic [7:0]                  flo1_ff, flo2_ff;

   lgtpg_pkg::frame_ctl_type ctl2;
   logic [SWEEP_W-1:0]       sweep2;
   logic [IDX_W-1:0]         sine_idx2;

   // stage 3: shaded colors and ROM output
   logic [lgtpg_pkg::CHAN_W-1:0] red_in, green_in, blue_in;
   logic                         sine_in;
   logic [lgtpg_pkg::CHAN_W-1:0] red3_ff, green3_ff, blue3_ff;
   logic                         sine3_ff;
   lgtpg_pkg::pattern_type       pat3_ff;
   logic [lgtpg_pkg::CHAN_W-1:0] level3;

   // stage 4: result register
   logic [lgtpg_pkg::CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   lgtpg_pkg::pattern_type       rsp_pat_ff;

   logic [9:0] hue_sum;

   // Hold everything while a finished result is refused downstream.
   assign advance   = !(stage_valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   // Advance valid bits one stage per moving cycle.
   assign stage_valid_in = advance ? {stage_valid_ff[STAGES-2:0], req_valid}
                                   : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Payload registers: no reset, gated by advance.
   always_ff @(posedge clock) begin
      if (advance) begin
         col0_ff   <= req_col;
         row0_ff   <= req_row;
         frame0_ff <= req_frame;
         col1_ff   <= col0_ff;
         row1_ff   <= row0_ff;
         flo1_ff   <= frame0_ff[7:0];
         col2_ff   <= col1_ff;
         row2_ff   <= row1_ff;
         flo2_ff   <= flo1_ff;
         red3_ff   <= red_in;
         green3_ff <= green_in;
         blue3_ff  <= blue_in;
         sine3_ff  <= sine_in;
         pat3_ff   <= ctl2.pattern;
      end
   end

   lgtpg_frame_decode #(
      .GRID_SIDE        (GRID_SIDE),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_decode (
      .clock    (clock),
      .advance  (advance),
      .frame    (frame0_ff),
      .ctl      (ctl2),
      .sweep    (sweep2),
      .sine_idx (sine_idx2)
   );

   lgtpg_pixel_shade #(
      .GRID_SIDE (GRID_SIDE)
   ) u_shade (
      .col      (col2_ff),
      .row      (row2_ff),
      .frame_lo (flo2_ff),
      .sweep    (sweep2),
      .ctl      (ctl2),
      .red      (red_in),
      .green    (green_in),
      .blue     (blue_in),
      .use_sine (sine_in)
   );

   lgtpg_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock   (clock),
      .advance (advance),
      .addr    (sine_idx2),
      .level   (level3)
   );

   // Drop in the sine level for in-grid pixels of the white sine pattern.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_red_ff   <= sine3_ff ? level3 : red3_ff;
         rsp_green_ff <= sine3_ff ? level3 : green3_ff;
         rsp_blue_ff  <= sine3_ff ? level3 : blue3_ff;
         rsp_pat_ff   <= pat3_ff;
      end
   end

   assign rsp_valid          = stage_valid_ff[STAGES-1];
   assign rsp_red            = rsp_red_ff;
   assign rsp_green          = rsp_green_ff;
   assign rsp_blue           = rsp_blue_ff;
   assign rsp_pattern_in_use = rsp_pat_ff;

   assign hue_sum = 10'(rsp_red) + 10'(rsp_green) + 10'(rsp_blue);

   `LGTPG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid right after reset")
   `LGTPG_ASSERT(a_accept_enters, clock, reset, (req_valid && !req_stall) |=> stage_valid_ff[0], "accepted request not in input stage")
   `LGTPG_ASSERT(a_red_dot_only, clock, reset, (rsp_valid && (rsp_pat_ff == lgtpg_pkg::PAT_RED_DOT)) |-> ((rsp_green == lgtpg_pkg::CHAN_OFF) && (rsp_blue == lgtpg_pkg::CHAN_OFF) && ((rsp_red == lgtpg_pkg::CHAN_OFF) || (rsp_red == lgtpg_pkg::CHAN_FULL))), "red dot pattern gave other colors")
   `LGTPG_ASSERT(a_white_gray, clock, reset, (rsp_valid && ((rsp_pat_ff == lgtpg_pkg::PAT_CHECKER) || (rsp_pat_ff == lgtpg_pkg::PAT_SINE_WHITE))) |-> ((rsp_red == rsp_green) && (rsp_green == rsp_blue)), "white pattern channels differ")
   `LGTPG_ASSERT(a_hue_energy, clock, reset, (rsp_valid && (rsp_pat_ff == lgtpg_pkg::PAT_HUE_WHEEL)) |-> ((hue_sum == 10'd255) || (hue_sum == 10'd0)), "hue wheel channels do not sum to full scale")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED grid test pattern generator - testbench
// Sends pixel requests through the valid/stall input channel and checks every
// returned pixel against an in-bench pixel predictor. The run covers directed
// corners, random frames, a long receiver hold-off and a gap-free frame sweep.
// ----------------------------------------------------------------------------
module tb_top;
   import lgtpg_pkg::*;

   // Block geometry and the fixed-point constants of the sine white pattern.
   localparam int unsigned        GRID               = GRID_SIDE_DEFAULT;
   localparam int unsigned        SINE_DEPTH         = SINE_TABLE_DEPTH_DEFAULT;
   localparam logic [FRAME_W-1:0] PHASE_STEP         = 32'd68356528;
   localparam longint unsigned    Q30_ONE            = 64'd1073741824;
   localparam longint unsigned    TWO_PI_Q30         = 64'd6746518852;
   localparam longint unsigned    PI_Q30             = 64'd3373259426;
   localparam longint unsigned    HALF_PI_Q30        = 64'd1686629713;
   localparam int unsigned        FRAMES_PER_PATTERN = 300;
   localparam int unsigned        PATTERN_COUNT      = 6;
   localparam int unsigned        LAST_PATTERN_START = 14316556;

   // Pipeline depth, used to size the end pause for stray results.
   localparam int unsigned LATENCY        = 4;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned REPORT_LIMIT   = 40;
   localparam int unsigned HOLD_OFF_LEN   = 80;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      pattern_type       pattern;
   } pixel_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [COL_W-1:0]   req_col;
   logic [ROW_W-1:0]   req_row;
   logic [FRAME_W-1:0] req_frame;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CHAN_W-1:0]  rsp_red;
   logic [CHAN_W-1:0]  rsp_green;
   logic [CHAN_W-1:0]  rsp_blue;
   logic [PAT_W-1:0]   rsp_pattern_in_use;

   // Pixels predicted for accepted requests, oldest first.
   pixel_type pending_pixels[$];

   int mismatches      = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int pattern_hits [PATTERN_COUNT];

   // Idling knobs, changed by the tests while the run goes on.
   int req_gap_pct     = 30;
   int rsp_stall_pct   = 25;
   int hold_off_cycles = 0;

   led_grid_test_pattern_generator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_col            (req_col),
      .req_row            (req_row),
      .req_frame          (req_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_pattern_in_use (rsp_pattern_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Pixel predictor
   // ---------------------------------------------------------------------

   // Sine of a Q2.30 angle in [0, pi/2] by Taylor series to the x^15 term,
   // clamped to [0, 1]; the two ends of the quarter wave are exact.
   function automatic longint unsigned sine_fraction(input longint unsigned angle);
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      int unsigned     k;
      if (angle == 0) return 0;
      if (angle >= HALF_PI_Q30) return Q30_ONE;
      x2   = (angle * angle) >> 30;
      term = angle;
      sum  = angle;
      for (k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k[0]) sum = sum - term;
         else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > Q30_ONE) sum = Q30_ONE;
      return sum;
   endfunction

   // Top bits of the wrapped phase: the sine table entry for this frame.
   function automatic longint unsigned sine_index(input logic [FRAME_W-1:0] frame);
      logic [FRAME_W-1:0] phase;
      longint unsigned    wide_phase;
      phase      = frame * PHASE_STEP;
      wide_phase = phase;
      return (wide_phase * SINE_DEPTH) >> 32;
   endfunction

   // White level 128 + 127*sin; round away from the midline on the low half.
   function automatic logic [CHAN_W-1:0] sine_level(input logic [FRAME_W-1:0] frame);
      longint unsigned angle;
      longint unsigned scaled;
      logic            negative;
      angle    = sine_index(frame) * TWO_PI_Q30 / SINE_DEPTH;
      negative = 1'b0;
      if (angle > PI_Q30) begin
         negative = 1'b1;
         angle    = angle - PI_Q30;
      end
      if (angle > HALF_PI_Q30) angle = (angle <= PI_Q30) ? PI_Q30 - angle : 0;
      scaled = 127 * sine_fraction(angle);
      if (negative) return 8'(128 - ((scaled + Q30_ONE - 1) >> 30));
      return 8'(128 + (scaled >> 30));
   endfunction

   function automatic pixel_type paint_pixel(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row,
                                             input logic [FRAME_W-1:0] frame);
      pixel_type        px;
      logic [PAT_W-1:0] code;
      int unsigned      x;
      int unsigned      y;
      int unsigned      sweep;
      int unsigned      hue;
      x          = col;
      y          = row;
      code       = 3'((frame / FRAMES_PER_PATTERN + 1) % PATTERN_COUNT);
      sweep      = (frame / 8) % GRID;
      px.red     = CHAN_OFF;
      px.green   = CHAN_OFF;
      px.blue    = CHAN_OFF;
      px.pattern = pattern_type'(code);
      // Pixels off the grid stay dark; 3-bit fields never leave an 8-wide grid.
      if (x < GRID && y < GRID) begin
         case (px.pattern)
            PAT_RED_DOT: begin
               if (x == sweep && y == sweep) px.red = CHAN_FULL;
            end
            PAT_GREEN_DOT: begin
               if (x == sweep && y == sweep) px.green = CHAN_FULL;
            end
            PAT_BLUE_BAND: begin
               if ((x + y) % GRID == sweep) px.blue = CHAN_FULL;
            end
            PAT_HUE_WHEEL: begin
               hue = (32 * x + 32 * y + frame) & 32'hFF;
               if (hue < 85) begin
                  px.red   = 8'(255 - 3 * hue);
                  px.green = 8'(3 * hue);
               end else if (hue < 170) begin
                  px.green = 8'(255 - 3 * (hue - 85));
                  px.blue  = 8'(3 * (hue - 85));
               end else begin
                  px.red   = 8'(3 * (hue - 170));
                  px.blue  = 8'(255 - 3 * (hue - 170));
               end
            end
            PAT_CHECKER: begin
               if ((((x + y) & 1) ^ ((frame / 30) & 1)) != 0) begin
                  px.red   = CHAN_FULL;
                  px.green = CHAN_FULL;
                  px.blue  = CHAN_FULL;
               end
            end
            default: begin
               px.red   = sine_level(frame);
               px.green = px.red;
               px.blue  = px.red;
            end
         endcase
      end
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Shared request driver, result checker, receiver and watchdog
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // Offer one request and hold it until taken, then record its pixel and
   // maybe drop valid for a random gap. Valid stays high across back-to-back
   // requests so it is never lowered and raised within one step.
   task automatic send_request(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                               input logic [FRAME_W-1:0] frame);
      int unsigned gap;
      req_valid <= 1'b1;
      req_col   <= col;
      req_row   <= row;
      req_frame <= frame;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_pixels.push_back(paint_pixel(col, row, frame));
      requests_sent++;
      if ($urandom_range(99) < req_gap_pct) begin
         // Mostly short gaps, now and then a long one.
         gap = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every predicted pixel has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Check each accepted result against the oldest predicted pixel.
   always @(posedge clock) begin : check_results
      pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("result with no request pending (rgb %0d %0d %0d)",
                                      rsp_red, rsp_green, rsp_blue));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red !== want.red)
               report_mismatch($sformatf("red got %0d, expected %0d", rsp_red, want.red));
            if (rsp_green !== want.green)
               report_mismatch($sformatf("green got %0d, expected %0d",
                                         rsp_green, want.green));
            if (rsp_blue !== want.blue)
               report_mismatch($sformatf("blue got %0d, expected %0d", rsp_blue, want.blue));
            if (rsp_pattern_in_use !== want.pattern)
               report_mismatch($sformatf("pattern got %0d, expected %0d",
                                         rsp_pattern_in_use, want.pattern));
            results_checked++;
            pattern_hits[want.pattern]++;
         end
      end
   end

   // Receiver: random stalls, mostly short with a few long ones, plus a long
   // hold-off on request from a test, counted here cycle by cycle.
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (stall_left == 0 && $urandom_range(99) < rsp_stall_pct) begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles, %0d results still pending",
               WATCHDOG_LIMIT, pending_pixels.size());
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, every pattern, pattern boundaries, frame wrap, hue wheel
   // segment edges, checker phases and the four quarter points of the sine.
   task automatic test_directed_corners();
      logic [FRAME_W-1:0] probe;
      pixel_type          px;
      int unsigned        quarter;
      send_request(3'd0, 3'd0, 32'd0);            // green dot lit at sweep 0
      send_request(3'd7, 3'd7, 32'hFFFF_FFFF);    // last frame before wrap
      send_request(3'd7, 3'd0, 32'd0);
      send_request(3'd3, 3'd3, 32'd24);           // green dot, sweep 3
      send_request(3'd7, 3'd7, 32'd299);          // last green dot frame
      send_request(3'd0, 3'd7, 32'd300);          // first blue band frame
      send_request(3'd3, 3'd5, 32'd320);          // blue band wraps past the grid
      // Hue wheel at the two segment edges and across the byte wrap.
      send_request(3'd0, 3'd0, 32'd767);
      send_request(3'd0, 3'd0, 32'd768);
      send_request(3'd0, 3'd0, 32'd852);
      send_request(3'd0, 3'd0, 32'd853);
      send_request(3'd0, 3'd0, 32'd681);
      send_request(3'd0, 3'd0, 32'd682);
      // Checker on both frame phases and both pixel parities.
      send_request(3'd0, 3'd0, 32'd1020);
      send_request(3'd1, 3'd0, 32'd1020);
      send_request(3'd0, 3'd0, 32'd1050);
      send_request(3'd5, 3'd5, 32'd1200);         // first sine white frame
      send_request(3'd7, 3'd7, 32'd1499);
      send_request(3'd5, 3'd5, 32'd1512);         // red dot lit at sweep 5
      send_request(3'd4, 3'd4, 32'd1799);
      // Search for sine frames landing on angle 0, pi/2, pi and 3pi/2.
      for (quarter = 0; quarter < 4; quarter++) begin
         probe = 32'd1199;
         do begin
            probe++;
            px = paint_pixel(3'd0, 3'd0, probe);
         end while ((px.pattern != PAT_SINE_WHITE || sine_index(probe) != quarter * SINE_DEPTH / 4)
                    && probe < 32'd100_000_000);
         send_request(3'd2, 3'd6, probe);
      end
   endtask

   // Random pixels; frames mix full range, pattern boundaries, the zero wrap
   // and low counts. Change the idling knobs every 200 requests.
   task automatic test_random_pixels(input int count);
      logic [FRAME_W-1:0] frame;
      int                 i;
      for (i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            req_gap_pct   = $urandom_range(0, 2) * 25;
            rsp_stall_pct = $urandom_range(0, 2) * 30;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: frame = $urandom;
            4, 5: frame = $urandom_range(0, LAST_PATTERN_START + 1) * FRAMES_PER_PATTERN
                          + $urandom_range(0, 15) - 8;
            6: frame = $urandom_range(0, 600) - 300;
            default: frame = $urandom_range(0, 20000);
         endcase
         send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), frame);
      end
      req_gap_pct   = 30;
      rsp_stall_pct = 25;
   endtask

   // Hold the receiver off while requests keep coming back to back, so the
   // pipeline fills and stalls its input; then pause until all have drained.
   task automatic test_backpressure();
      int i;
      req_gap_pct     = 0;
      hold_off_cycles = HOLD_OFF_LEN;
      for (i = 0; i < 150; i++)
         send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
      wait_for_results();
      req_gap_pct = 30;
   endtask

   // Sweep the whole grid over consecutive frames across a pattern change,
   // with no idling on either side.
   task automatic test_frame_sweep();
      logic [FRAME_W-1:0] start;
      int                 i;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      start = $urandom_range(1, LAST_PATTERN_START) * FRAMES_PER_PATTERN - 32;
      for (i = 0; i < 256; i++)
         send_request(3'(i % GRID), 3'(i / GRID), start + i / 4);
      req_gap_pct   = 30;
      rsp_stall_pct = 25;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_col   = '0;
      req_row   = '0;
      req_frame = '0;
      rsp_stall = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_pixels(1020);
      test_backpressure();
      test_frame_sweep();

      // Drain, then pause for stray results.
      wait_for_results();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Covered %0d pixel requests, %0d results checked: corners, random frames,",
               requests_sent, results_checked);
      $display("receiver hold-off and grid sweep; hits per pattern %0d %0d %0d %0d %0d %0d",
               pattern_hits[0], pattern_hits[1], pattern_hits[2],
               pattern_hits[3], pattern_hits[4], pattern_hits[5]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/lgtpg_pkg.sv
src/lgtpg_frame_decode.sv
src/lgtpg_sine_rom.sv
src/lgtpg_pixel_shade.sv
src/led_grid_test_pattern_generator_unit.sv
tb/tb_top.sv
